// ----- hdl/uthb_pkg.sv -----
`timescale 1ns / 1ps
package uthb_pkg;

  localparam int unsigned TAIL_BYTES_DEF   = 16;
  localparam int unsigned HASH_W           = 32;
  localparam int unsigned SIZE_W           = 31;
  localparam logic [31:0] SEED_PHI         = 32'h9e3779b9;
  localparam logic [30:0] TABLE_SIZE_RESET = 31'd217;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_last;
    logic       no_byte;
  } in_word_t;

  typedef struct packed {
    logic [30:0] bucket_index;
    logic [31:0] hash_value;
  } out_word_t;

  // Operations of the shared hash step unit.
  typedef enum logic [2:0] {
    OP_ADD,
    OP_MIX,
    OP_F1,
    OP_F2,
    OP_F3
  } uthb_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_LEN,
    S_ADD_TAIL,
    S_MIX,
    S_F1,
    S_F2,
    S_F3,
    S_DIV
  } uthb_state_t;

endpackage

// ----- hdl/url_tail_hash_bucket.sv -----
`timescale 1ns / 1ps
// Key bytes are taken one word per cycle while start is high and busy is low; a word with key_last ends the key.
// A key-end word keeps busy high while the step unit adds the length to the seed and mixes,
// adds and mixes each tail byte and runs the final mix steps, and while the bit-serial
// remainder unit runs. out_valid rises at the edge where busy falls; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer, key length and strobe, and sets
// table_size to 217; the tail window holds no reset value.
module url_tail_hash_bucket #(
  parameter int unsigned TAIL_BYTES = uthb_pkg::TAIL_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  uthb_pkg::in_word_t  in_word,
  output logic                out_valid,
  output uthb_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [30:0]         cfg_wdata
);
  import uthb_pkg::*;

  localparam int unsigned CW = $clog2(TAIL_BYTES + 1);

  uthb_state_t state_r, state_nxt;

  // Tail window, newest byte at entry 0. While hashing it shifts toward
  // entry 0 so the step unit always reads the same place.
  logic [7:0]    window_r [TAIL_BYTES];
  logic [31:0]   key_length_r;
  logic [31:0]   len_nxt;
  logic [CW-1:0] cnt_r;
  logic [31:0]   hash_r;
  logic [30:0]   table_size_r;
  logic [30:0]   divisor;
  logic          out_valid_r;
  out_word_t     out_word_r;

  uthb_op_t    op;
  logic [31:0] alu_v;
  logic [31:0] alu_out;
  logic        accept;
  logic        mod_start;
  logic        mod_done;
  logic [30:0] mod_rem;

  assign accept  = start && !busy;
  assign len_nxt = key_length_r + {31'd0, !in_word.no_byte};
  assign divisor = (table_size_r == '0) ? 31'd1 : table_size_r;

  // The shared step unit: every add, shift and xor of the hash passes through it.
  uthb_alu u_alu (
    .op    (op),
    .h_in  (hash_r),
    .v_in  (alu_v),
    .h_out (alu_out)
  );

  // The final hash goes straight from the step unit into the remainder unit.
  uthb_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (alu_out),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: add the length to the seed and mix, then one add and one mix per tail byte,
  // then the three final mix steps and the remainder.
  always_comb begin
    state_nxt = state_r;
    op        = OP_ADD;
    alu_v     = {24'd0, window_r[0]};
    mod_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_word.key_last) begin
          state_nxt = S_ADD_LEN;
        end
      end
      S_ADD_LEN: begin
        alu_v     = key_length_r;
        state_nxt = S_MIX;
      end
      S_ADD_TAIL: begin
        state_nxt = S_MIX;
      end
      S_MIX: begin
        op        = OP_MIX;
        state_nxt = (cnt_r != '0) ? S_ADD_TAIL : S_F1;
      end
      S_F1: begin
        op        = OP_F1;
        state_nxt = S_F2;
      end
      S_F2: begin
        op        = OP_F2;
        state_nxt = S_F3;
      end
      S_F3: begin
        op        = OP_F3;
        mod_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (mod_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Control registers: key length, tail count, table size and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= '0;
      cnt_r        <= '0;
      table_size_r <= TABLE_SIZE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DIV) && mod_done;
      if (cfg_we) begin
        table_size_r <= cfg_wdata;
      end
      if (accept) begin
        key_length_r <= len_nxt;
        if (len_nxt >= TAIL_BYTES) begin
          cnt_r <= CW'(TAIL_BYTES);
        end else begin
          cnt_r <= len_nxt[CW-1:0];
        end
      end else if (state_r == S_ADD_LEN) begin
        // The length has been mixed in; the next key starts from zero.
        key_length_r <= '0;
      end else if (state_r == S_ADD_TAIL) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Datapath registers: window, running hash and result word.
  always_ff @(posedge clk) begin
    if (accept && !in_word.no_byte) begin
      window_r[0] <= in_word.key_byte;
      for (int i = 1; i < TAIL_BYTES; i++) begin
        window_r[i] <= window_r[i-1];
      end
    end else if (state_r == S_ADD_TAIL) begin
      for (int i = 0; i < TAIL_BYTES - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
    end

    if (accept && in_word.key_last) begin
      hash_r <= SEED_PHI;
    end else if (state_r != S_IDLE && state_r != S_DIV) begin
      hash_r <= alu_out;
    end

    if (state_r == S_DIV && mod_done) begin
      out_word_r.bucket_index <= mod_rem;
      out_word_r.hash_value   <= hash_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- hdl/uthb_alu.sv -----
`timescale 1ns / 1ps
module uthb_alu (
  input  uthb_pkg::uthb_op_t op,
  input  logic [31:0]        h_in,
  input  logic [31:0]        v_in,
  output logic [31:0]        h_out
);
  import uthb_pkg::*;

  logic [31:0] mix_t;

  // One step of the hash per cycle; each op holds at most one add.
  always_comb begin
    mix_t = h_in + (h_in << 10);
    case (op)
      OP_ADD:  h_out = h_in + v_in;
      OP_MIX:  h_out = mix_t ^ (mix_t << 6);
      OP_F1:   h_out = h_in + (h_in << 3);
      OP_F2:   h_out = h_in ^ (h_in >> 11);
      OP_F3:   h_out = h_in + (h_in << 15);
      default: h_out = h_in;
    endcase
  end

endmodule

// ----- hdl/uthb_mod.sv -----
`timescale 1ns / 1ps
module uthb_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [30:0] remainder
);
  import uthb_pkg::*;

  logic [31:0] q_r;
  logic [30:0] rem_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [31:0] trial;
  logic [31:0] diff;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  always_comb begin
    trial = {rem_r, q_r[31]};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      q_r <= {q_r[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_r <= diff[30:0];
      end else begin
        rem_r <= trial[30:0];
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
